@@ src/htbi_pkg.sv @@
// Shared types and constants of the tension/bias Hermite interpolator.
`timescale 1ns / 1ps
`default_nettype none
package htbi_pkg;

   localparam int SAMPLE_W  = 32;   // signed sample word
   localparam int FRAC_W    = 17;   // unsigned position word
   localparam int GAIN_W    = 18;   // signed tension and bias words
   localparam int DIFF_W    = 33;   // difference of two samples
   localparam int TANGENT_W = 36;   // rounded tangent, in sample units

   // Pipeline stage indexes
   localparam int ST_PREP   = 0;    // clamp, differences, gain products, t*t
   localparam int ST_GAIN   = 1;    // rounded gains and t^2
   localparam int ST_PROD   = 2;    // tangent products and t^2*t
   localparam int ST_TAN    = 3;    // rounded tangents and t^3
   localparam int ST_WEIGHT = 4;    // basis weights
   localparam int ST_BLEND  = 5;    // weight products
   localparam int ST_SUM    = 6;    // rounded sum
   localparam int ST_OUT    = 7;    // saturated result
   localparam int STAGES    = 8;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } pipe_ctrl_type;

endpackage
`default_nettype wire

@@ src/hermite_tension_bias_interpolator.sv @@
// Throughput: one word per cycle; every stage holds its word while the next is full, so
// a stalled response backs the pipeline up without loss and bubbles close up.
// Reset clears the stage valid bits only; data registers keep whatever they hold.
// The eight register stages split the work at each multiplier and each rounding add.
`timescale 1ns / 1ps
`default_nettype none
module hermite_tension_bias_interpolator #(
   parameter int FRAC_BITS = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // sample_before[31:0], sample_start[63:32], sample_end[95:64], sample_after[127:96],
   // fraction[144:128], tension_value[162:145], bias_value[180:163], zero pad[183:181]
   input  wire [183:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // interpolated[31:0]
   output logic [31:0]  rsp_tdata,
   // saturated_flag[0]
   output logic [0:0]   rsp_tuser
);

   localparam int WEIGHT_W = ((FRAC_BITS > htbi_pkg::FRAC_W) ? FRAC_BITS
                                                             : htbi_pkg::FRAC_W) + 4;

   htbi_pkg::pipe_ctrl_type ctrl;

   logic signed [htbi_pkg::SAMPLE_W-1:0]  start_w, end_w, result;
   logic signed [htbi_pkg::TANGENT_W-1:0] tangent0, tangent1;
   logic signed [WEIGHT_W-1:0]            weight0, weight1, weight2, weight3;
   logic                                  sat;

   htbi_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .ctrl      (ctrl)
   );

   htbi_tangent #(
      .FRAC_BITS (FRAC_BITS)
   ) u_tangent (
      .clock         (clock),
      .ctrl          (ctrl),
      .sample_before (req_tdata[31:0]),
      .sample_start  (req_tdata[63:32]),
      .sample_end    (req_tdata[95:64]),
      .sample_after  (req_tdata[127:96]),
      .tension_value (req_tdata[162:145]),
      .bias_value    (req_tdata[180:163]),
      .start_out     (start_w),
      .end_out       (end_w),
      .tangent0_out  (tangent0),
      .tangent1_out  (tangent1)
   );

   htbi_basis #(
      .FRAC_BITS (FRAC_BITS),
      .WEIGHT_W  (WEIGHT_W)
   ) u_basis (
      .clock    (clock),
      .ctrl     (ctrl),
      .fraction (req_tdata[144:128]),
      .weight0  (weight0),
      .weight1  (weight1),
      .weight2  (weight2),
      .weight3  (weight3)
   );

   htbi_blend #(
      .FRAC_BITS (FRAC_BITS),
      .WEIGHT_W  (WEIGHT_W)
   ) u_blend (
      .clock          (clock),
      .ctrl           (ctrl),
      .weight0        (weight0),
      .weight1        (weight1),
      .weight2        (weight2),
      .weight3        (weight3),
      .sample_start   (start_w),
      .sample_end     (end_w),
      .tangent0       (tangent0),
      .tangent1       (tangent1),
      .interpolated   (result),
      .saturated_flag (sat)
   );

   assign rsp_tdata = result;
   assign rsp_tuser = sat;

endmodule
`default_nettype wire

@@ src/htbi_pipe_ctrl.sv @@
// Valid bits and per-stage load enables of the interpolator pipeline.
`timescale 1ns / 1ps
`default_nettype none
module htbi_pipe_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  wire                   out_ready,
   output htbi_pkg::pipe_ctrl_type ctrl
);

   logic [htbi_pkg::STAGES-1:0] valid_ff;
   logic [htbi_pkg::STAGES-1:0] valid_in;
   logic [htbi_pkg::STAGES-1:0] free;

   // A stage may load when it is empty or its word moves on this cycle
   always_comb begin
      free[htbi_pkg::STAGES-1] = !valid_ff[htbi_pkg::STAGES-1] || out_ready;
      for (int k = htbi_pkg::STAGES-2; k >= 0; k--) begin
         free[k] = !valid_ff[k] || free[k+1];
      end
      valid_in[0] = free[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < htbi_pkg::STAGES; k++) begin
         valid_in[k] = free[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load = free;
   assign in_ready  = free[0];
   assign out_valid = valid_ff[htbi_pkg::STAGES-1];

endmodule
`default_nettype wire

@@ src/htbi_tangent.sv @@
// Tension/bias gains and the two end tangents, with the samples carried alongside.
`timescale 1ns / 1ps
`default_nettype none
module htbi_tangent #(
   parameter int FRAC_BITS = 16
) (
   input  wire                                      clock,
   input  htbi_pkg::pipe_ctrl_type                  ctrl,
   input  wire signed [htbi_pkg::SAMPLE_W-1:0]      sample_before,
   input  wire signed [htbi_pkg::SAMPLE_W-1:0]      sample_start,
   input  wire signed [htbi_pkg::SAMPLE_W-1:0]      sample_end,
   input  wire signed [htbi_pkg::SAMPLE_W-1:0]      sample_after,
   input  wire signed [htbi_pkg::GAIN_W-1:0]        tension_value,
   input  wire signed [htbi_pkg::GAIN_W-1:0]        bias_value,
   output logic signed [htbi_pkg::SAMPLE_W-1:0]     start_out,
   output logic signed [htbi_pkg::SAMPLE_W-1:0]     end_out,
   output logic signed [htbi_pkg::TANGENT_W-1:0]    tangent0_out,
   output logic signed [htbi_pkg::TANGENT_W-1:0]    tangent1_out
);

   localparam int GW  = ((FRAC_BITS > htbi_pkg::GAIN_W - 1) ? FRAC_BITS
                                                            : htbi_pkg::GAIN_W - 1) + 3;
   localparam int PW  = 2 * GW;
   localparam int KW  = FRAC_BITS + 3;
   localparam int RW  = htbi_pkg::DIFF_W + KW;
   localparam int SW  = RW + 1;
   localparam int DW  = htbi_pkg::DIFF_W;
   localparam int MW  = htbi_pkg::TANGENT_W;

   localparam logic signed [GW-1:0] ONE_G     = GW'(1) << FRAC_BITS;
   localparam logic signed [GW-1:0] NEG_ONE_G = -ONE_G;
   localparam logic signed [PW-1:0] GAIN_HALF = PW'(1) << FRAC_BITS;
   localparam logic signed [SW-1:0] TAN_HALF  = SW'(1) << (FRAC_BITS - 1);

   logic signed [GW-1:0] ten_ext, bia_ext, ten_c, bia_c, ct, up, dn;
   logic signed [PW-1:0] kp_prod_in, km_prod_in, kp_prod_ff, km_prod_ff;
   logic signed [PW-1:0] kp_sum, km_sum, kp_shift, km_shift;
   logic signed [KW-1:0] kp_in, km_in, kp_ff, km_ff;
   logic signed [DW-1:0] d0_in, d1_in, d2_in;
   logic signed [DW-1:0] d0_ff, d1_ff, d2_ff, d0_g_ff, d1_g_ff, d2_g_ff;
   logic signed [RW-1:0] p00_in, p01_in, p10_in, p11_in;
   logic signed [RW-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [SW-1:0] sum0, sum1, m0_shift, m1_shift;
   logic signed [MW-1:0] m0_in, m1_in, m0_ff, m1_ff, m0_w_ff, m1_w_ff;
   logic signed [htbi_pkg::SAMPLE_W-1:0] s1_ff [htbi_pkg::ST_WEIGHT+1];
   logic signed [htbi_pkg::SAMPLE_W-1:0] s2_ff [htbi_pkg::ST_WEIGHT+1];

   // Clamp tension and bias to the unit range, form both gain products and the sample differences
   always_comb begin
      ten_ext = GW'(tension_value);
      bia_ext = GW'(bias_value);
      ten_c = (ten_ext > ONE_G) ? ONE_G : ((ten_ext < NEG_ONE_G) ? NEG_ONE_G : ten_ext);
      bia_c = (bia_ext > ONE_G) ? ONE_G : ((bia_ext < NEG_ONE_G) ? NEG_ONE_G : bia_ext);
      ct = ONE_G - ten_c;
      up = ONE_G + bia_c;
      dn = ONE_G - bia_c;
      kp_prod_in = PW'(up) * PW'(ct);
      km_prod_in = PW'(dn) * PW'(ct);
      d0_in = DW'(sample_start) - DW'(sample_before);
      d1_in = DW'(sample_end)   - DW'(sample_start);
      d2_in = DW'(sample_after) - DW'(sample_end);
   end

   always_comb begin
      kp_sum   = kp_prod_ff + GAIN_HALF;
      km_sum   = km_prod_ff + GAIN_HALF;
      kp_shift = kp_sum >>> (FRAC_BITS + 1);
      km_shift = km_sum >>> (FRAC_BITS + 1);
      kp_in    = kp_shift[KW-1:0];
      km_in    = km_shift[KW-1:0];
   end

   always_comb begin
      p00_in = RW'(d0_g_ff) * RW'(kp_ff);
      p01_in = RW'(d1_g_ff) * RW'(km_ff);
      p10_in = RW'(d1_g_ff) * RW'(kp_ff);
      p11_in = RW'(d2_g_ff) * RW'(km_ff);
   end

   always_comb begin
      sum0     = SW'(p00_ff) + SW'(p01_ff) + TAN_HALF;
      sum1     = SW'(p10_ff) + SW'(p11_ff) + TAN_HALF;
      m0_shift = sum0 >>> FRAC_BITS;
      m1_shift = sum1 >>> FRAC_BITS;
      m0_in    = m0_shift[MW-1:0];
      m1_in    = m1_shift[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[htbi_pkg::ST_PREP]) begin
         kp_prod_ff <= kp_prod_in;
         km_prod_ff <= km_prod_in;
         d0_ff      <= d0_in;
         d1_ff      <= d1_in;
         d2_ff      <= d2_in;
         s1_ff[htbi_pkg::ST_PREP] <= sample_start;
         s2_ff[htbi_pkg::ST_PREP] <= sample_end;
      end
      if (ctrl.load[htbi_pkg::ST_GAIN]) begin
         kp_ff   <= kp_in;
         km_ff   <= km_in;
         d0_g_ff <= d0_ff;
         d1_g_ff <= d1_ff;
         d2_g_ff <= d2_ff;
      end
      if (ctrl.load[htbi_pkg::ST_PROD]) begin
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
      end
      if (ctrl.load[htbi_pkg::ST_TAN]) begin
         m0_ff <= m0_in;
         m1_ff <= m1_in;
      end
      if (ctrl.load[htbi_pkg::ST_WEIGHT]) begin
         m0_w_ff <= m0_ff;
         m1_w_ff <= m1_ff;
      end
      for (int k = 1; k <= htbi_pkg::ST_WEIGHT; k++) begin
         if (ctrl.load[k]) begin
            s1_ff[k] <= s1_ff[k-1];
            s2_ff[k] <= s2_ff[k-1];
         end
      end
   end

   assign start_out    = s1_ff[htbi_pkg::ST_WEIGHT];
   assign end_out      = s2_ff[htbi_pkg::ST_WEIGHT];
   assign tangent0_out = m0_w_ff;
   assign tangent1_out = m1_w_ff;

endmodule
`default_nettype wire

@@ src/htbi_basis.sv @@
// Powers of the position and the four cubic Hermite basis weights.
`timescale 1ns / 1ps
`default_nettype none
module htbi_basis #(
   parameter int FRAC_BITS = 16,
   parameter int WEIGHT_W  = 21
) (
   input  wire                               clock,
   input  htbi_pkg::pipe_ctrl_type           ctrl,
   input  wire [htbi_pkg::FRAC_W-1:0]        fraction,
   output logic signed [WEIGHT_W-1:0]        weight0,
   output logic signed [WEIGHT_W-1:0]        weight1,
   output logic signed [WEIGHT_W-1:0]        weight2,
   output logic signed [WEIGHT_W-1:0]        weight3
);

   localparam int TW = htbi_pkg::FRAC_W;
   localparam int QW = 2 * TW;
   localparam int HW = QW + 1;

   localparam logic [31:0]          ONE_U  = 32'(1) << FRAC_BITS;
   localparam logic [HW-1:0]        HALF_T = HW'(1) << (FRAC_BITS - 1);
   localparam logic signed [WEIGHT_W-1:0] ONE_A = WEIGHT_W'(1) << FRAC_BITS;

   logic [TW-1:0] t_in, t2_in, t3_in;
   logic [TW-1:0] t_ff [htbi_pkg::ST_TAN+1];
   logic [TW-1:0] t2_ff, t2_p_ff, t2_t_ff, t3_ff;
   logic [QW-1:0] tt_in, tt_ff, ttt_in, ttt_ff;
   logic [HW-1:0] t2_full, t3_full;
   logic signed [WEIGHT_W-1:0] tw, t2w, t3w;
   logic signed [WEIGHT_W-1:0] w0_in, w1_in, w2_in, w3_in;
   logic signed [WEIGHT_W-1:0] w0_ff, w1_ff, w2_ff, w3_ff;

   // Position above one counts as one
   always_comb begin
      t_in  = ({{(32-TW){1'b0}}, fraction} > ONE_U) ? ONE_U[TW-1:0] : fraction;
      tt_in = QW'(t_in) * QW'(t_in);
   end

   always_comb begin
      t2_full = {1'b0, tt_ff} + HALF_T;
      t2_in   = TW'(t2_full >> FRAC_BITS);
      ttt_in  = QW'(t2_ff) * QW'(t_ff[htbi_pkg::ST_GAIN]);
      t3_full = {1'b0, ttt_ff} + HALF_T;
      t3_in   = TW'(t3_full >> FRAC_BITS);
   end

   always_comb begin
      tw    = WEIGHT_W'(t_ff[htbi_pkg::ST_TAN]);
      t2w   = WEIGHT_W'(t2_t_ff);
      t3w   = WEIGHT_W'(t3_ff);
      w0_in = (t3w <<< 1) - ((t2w <<< 1) + t2w) + ONE_A;
      w1_in = t3w - (t2w <<< 1) + tw;
      w2_in = t3w - t2w;
      w3_in = ((t2w <<< 1) + t2w) - (t3w <<< 1);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[htbi_pkg::ST_PREP]) begin
         t_ff[htbi_pkg::ST_PREP] <= t_in;
         tt_ff <= tt_in;
      end
      if (ctrl.load[htbi_pkg::ST_GAIN]) begin
         t2_ff <= t2_in;
      end
      if (ctrl.load[htbi_pkg::ST_PROD]) begin
         ttt_ff  <= ttt_in;
         t2_p_ff <= t2_ff;
      end
      if (ctrl.load[htbi_pkg::ST_TAN]) begin
         t3_ff   <= t3_in;
         t2_t_ff <= t2_p_ff;
      end
      for (int k = 1; k <= htbi_pkg::ST_TAN; k++) begin
         if (ctrl.load[k]) begin
            t_ff[k] <= t_ff[k-1];
         end
      end
      if (ctrl.load[htbi_pkg::ST_WEIGHT]) begin
         w0_ff <= w0_in;
         w1_ff <= w1_in;
         w2_ff <= w2_in;
         w3_ff <= w3_in;
      end
   end

   assign weight0 = w0_ff;
   assign weight1 = w1_ff;
   assign weight2 = w2_ff;
   assign weight3 = w3_ff;

endmodule
`default_nettype wire

@@ src/htbi_blend.sv @@
// Weighted sum of samples and tangents, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module htbi_blend #(
   parameter int FRAC_BITS = 16,
   parameter int WEIGHT_W  = 21
) (
   input  wire                                    clock,
   input  htbi_pkg::pipe_ctrl_type                ctrl,
   input  wire signed [WEIGHT_W-1:0]              weight0,
   input  wire signed [WEIGHT_W-1:0]              weight1,
   input  wire signed [WEIGHT_W-1:0]              weight2,
   input  wire signed [WEIGHT_W-1:0]              weight3,
   input  wire signed [htbi_pkg::SAMPLE_W-1:0]    sample_start,
   input  wire signed [htbi_pkg::SAMPLE_W-1:0]    sample_end,
   input  wire signed [htbi_pkg::TANGENT_W-1:0]   tangent0,
   input  wire signed [htbi_pkg::TANGENT_W-1:0]   tangent1,
   output logic signed [htbi_pkg::SAMPLE_W-1:0]   interpolated,
   output logic                                   saturated_flag
);

   localparam int QW = WEIGHT_W + htbi_pkg::TANGENT_W;
   localparam int AW = QW + 2;
   localparam int SW = htbi_pkg::SAMPLE_W;

   localparam logic signed [AW-1:0] HALF_R = AW'(1) << (FRAC_BITS - 1);
   localparam logic signed [AW-1:0] MAX_R  = AW'({1'b0, {(SW-1){1'b1}}});
   localparam logic signed [AW-1:0] MIN_R  = -MAX_R - AW'(1);

   logic signed [QW-1:0] q0_in, q1_in, q2_in, q3_in;
   logic signed [QW-1:0] q0_ff, q1_ff, q2_ff, q3_ff;
   logic signed [AW-1:0] acc, r_in, r_ff;
   logic signed [SW-1:0] y_in, y_ff;
   logic                 sat_in, sat_ff;

   always_comb begin
      q0_in = QW'(weight0) * QW'(sample_start);
      q1_in = QW'(weight1) * QW'(tangent0);
      q2_in = QW'(weight2) * QW'(tangent1);
      q3_in = QW'(weight3) * QW'(sample_end);
   end

   always_comb begin
      acc  = AW'(q0_ff) + AW'(q1_ff) + AW'(q2_ff) + AW'(q3_ff) + HALF_R;
      r_in = acc >>> FRAC_BITS;
   end

   // Clip to the word range and flag it
   always_comb begin
      if (r_ff > MAX_R) begin
         y_in   = MAX_R[SW-1:0];
         sat_in = 1'b1;
      end else if (r_ff < MIN_R) begin
         y_in   = MIN_R[SW-1:0];
         sat_in = 1'b1;
      end else begin
         y_in   = r_ff[SW-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[htbi_pkg::ST_BLEND]) begin
         q0_ff <= q0_in;
         q1_ff <= q1_in;
         q2_ff <= q2_in;
         q3_ff <= q3_in;
      end
      if (ctrl.load[htbi_pkg::ST_SUM]) begin
         r_ff <= r_in;
      end
      if (ctrl.load[htbi_pkg::ST_OUT]) begin
         y_ff   <= y_in;
         sat_ff <= sat_in;
      end
   end

   assign interpolated   = y_ff;
   assign saturated_flag = sat_ff;

endmodule
`default_nettype wire
